>>> hdl/i2a_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
package i2a_pkg;

   localparam int VALUE_W = 64;
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 7;
   localparam int INDEX_W = 5;
   localparam int NDIG_W  = 5;
   localparam int BCD_W   = 40;
   localparam int LOW_W   = 32;
   localparam int PC_W    = 3;

   localparam logic [FUNC_W-1:0] FUNC_DEC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOWER = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPPER = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_PTR   = 2'd3;

   localparam logic [NDIG_W-1:0] NDIG_DEC = 5'd10;
   localparam logic [NDIG_W-1:0] NDIG_HEX = 5'd8;
   localparam logic [NDIG_W-1:0] NDIG_PTR = 5'd16;
   localparam logic [NDIG_W-1:0] BCD_LAST_BIT = 5'd31;

   localparam logic [CHAR_W-1:0] ASC_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] ASC_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] ASC_X       = 7'h78;
   localparam logic [CHAR_W-1:0] ASC_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] ASC_LOWER_A = 7'h61;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_BCD,
      OP_UNPACK,
      OP_SKIP,
      OP_EMIT,
      OP_DIGIT
   } op_type;

   typedef enum logic [1:0] {
      CH_MINUS,
      CH_ZERO,
      CH_X,
      CH_DIGIT
   } chr_type;

   typedef struct packed {
      op_type  op;
      chr_type chr;
      logic    fire;
      logic    emit;
   } ctrl_type;

   typedef struct packed {
      logic more;
      logic neg;
      logic ptr;
      logic out_free;
   } status_type;

endpackage

>>> hdl/i2a_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module i2a_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [i2a_pkg::FUNC_W-1:0] req_func,
   input  i2a_pkg::status_type        status,
   output i2a_pkg::ctrl_type          ctrl
);

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_LOOP,
      BR_DONE,
      BR_DISPATCH
   } br_type;

   typedef enum logic [1:0] {
      G_ALWAYS,
      G_NEG,
      G_PTR
   } guard_type;

   typedef struct packed {
      i2a_pkg::op_type          op;
      i2a_pkg::chr_type         chr;
      guard_type                guard;
      br_type                   br;
      logic [i2a_pkg::PC_W-1:0] target;
   } ucode_type;

   localparam logic [i2a_pkg::PC_W-1:0] PC_IDLE = 3'd0;
   localparam logic [i2a_pkg::PC_W-1:0] PC_SKIP = 3'd3;

   function automatic ucode_type rom(input logic [i2a_pkg::PC_W-1:0] pc);
      ucode_type w;
      w = '{i2a_pkg::OP_IDLE, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_DONE, PC_IDLE};
      unique case (pc)
         3'd0: w = '{i2a_pkg::OP_IDLE, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_DISPATCH, PC_SKIP};
         3'd1: w = '{i2a_pkg::OP_BCD, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_LOOP, PC_IDLE};
         3'd2: w = '{i2a_pkg::OP_UNPACK, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_NEXT, PC_IDLE};
         3'd3: w = '{i2a_pkg::OP_SKIP, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_LOOP, PC_IDLE};
         3'd4: w = '{i2a_pkg::OP_EMIT, i2a_pkg::CH_MINUS, G_NEG, BR_NEXT, PC_IDLE};
         3'd5: w = '{i2a_pkg::OP_EMIT, i2a_pkg::CH_ZERO, G_PTR, BR_NEXT, PC_IDLE};
         3'd6: w = '{i2a_pkg::OP_EMIT, i2a_pkg::CH_X, G_PTR, BR_NEXT, PC_IDLE};
         3'd7: w = '{i2a_pkg::OP_DIGIT, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_DONE, PC_IDLE};
         default: w = '{i2a_pkg::OP_IDLE, i2a_pkg::CH_DIGIT, G_ALWAYS, BR_DONE, PC_IDLE};
      endcase
      return w;
   endfunction

   logic [i2a_pkg::PC_W-1:0] pc_ff, pc_in;
   ucode_type                uw;
   logic                     guard_ok;
   logic                     need_emit;
   logic                     fire;

   assign uw = rom(pc_ff);

   always_comb begin
      unique case (uw.guard)
         G_NEG:   guard_ok = status.neg;
         G_PTR:   guard_ok = status.ptr;
         default: guard_ok = 1'b1;
      endcase
   end

   always_comb begin
      need_emit = 1'b0;
      fire      = 1'b1;
      if (uw.op == i2a_pkg::OP_IDLE) begin
         fire = req_valid;
      end else if (uw.op == i2a_pkg::OP_EMIT || uw.op == i2a_pkg::OP_DIGIT) begin
         need_emit = guard_ok;
         // hold the step while the output register is still occupied
         fire      = !guard_ok || status.out_free;
      end
   end

   assign ctrl.op   = uw.op;
   assign ctrl.chr  = uw.chr;
   assign ctrl.fire = fire;
   assign ctrl.emit = need_emit && fire;

   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         unique case (uw.br)
            BR_NEXT: pc_in = pc_ff + 3'd1;
            BR_LOOP: pc_in = status.more ? pc_ff : pc_ff + 3'd1;
            BR_DONE: pc_in = status.more ? pc_ff : uw.target;
            BR_DISPATCH: begin
               pc_in = (req_func == i2a_pkg::FUNC_DEC) ? pc_ff + 3'd1 : uw.target;
            end
            default: pc_in = PC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> hdl/i2a_dp.sv
// Datapath: digit word, BCD converter, counters and the output register.
module i2a_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  i2a_pkg::ctrl_type           ctrl,
   input  logic [i2a_pkg::VALUE_W-1:0] req_value,
   input  logic [i2a_pkg::FUNC_W-1:0]  req_func,
   input  logic                        rsp_stall,
   output i2a_pkg::status_type         status,
   output logic                        rsp_valid,
   output logic [i2a_pkg::CHAR_W-1:0]  rsp_ascii_char,
   output logic [i2a_pkg::INDEX_W-1:0] rsp_char_index,
   output logic                        rsp_last
);

   function automatic logic [i2a_pkg::BCD_W-1:0] bcd_adjust(
      input logic [i2a_pkg::BCD_W-1:0] b);
      logic [i2a_pkg::BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < i2a_pkg::BCD_W / 4; i++) begin
         if (r[4*i +: 4] >= 4'd5) r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
      return r;
   endfunction

   function automatic logic [i2a_pkg::CHAR_W-1:0] digit_char(input logic [3:0] nib,
                                                          input logic upper);
      logic [i2a_pkg::CHAR_W-1:0] base;
      base = upper ? i2a_pkg::ASC_UPPER_A : i2a_pkg::ASC_LOWER_A;
      if (nib < 4'd10) return i2a_pkg::ASC_ZERO + {3'b000, nib};
      return base + {3'b000, nib} - 7'd10;
   endfunction

   logic [i2a_pkg::VALUE_W-1:0] work_ff, work_in;
   logic [i2a_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [i2a_pkg::NDIG_W-1:0]  ndig_ff, ndig_in;
   logic [i2a_pkg::NDIG_W-1:0]  cnt_ff, cnt_in;
   logic [i2a_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic                        neg_ff, neg_in;
   logic [i2a_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [i2a_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [i2a_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [i2a_pkg::LOW_W-1:0]   low;
   logic [3:0]                  top_nib;
   logic                        more;
   logic [i2a_pkg::BCD_W-1:0]   bcd_adj;

   assign low     = req_value[i2a_pkg::LOW_W-1:0];
   assign top_nib = work_ff[i2a_pkg::VALUE_W-1 -: 4];
   assign bcd_adj = bcd_adjust(bcd_ff);

   always_comb begin
      unique case (ctrl.op)
         i2a_pkg::OP_BCD:   more = (cnt_ff != '0);
         i2a_pkg::OP_SKIP:  more = (top_nib == 4'd0) && (ndig_ff != 5'd1);
         i2a_pkg::OP_DIGIT: more = (ndig_ff != 5'd1);
         default:           more = 1'b0;
      endcase
   end

   assign status.more     = more;
   assign status.neg      = neg_ff;
   assign status.ptr      = (func_ff == i2a_pkg::FUNC_PTR);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      work_in = work_ff;
      bcd_in  = bcd_ff;
      ndig_in = ndig_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      neg_in  = neg_ff;
      func_in = func_ff;
      if (ctrl.fire) begin
         unique case (ctrl.op)
            i2a_pkg::OP_IDLE: begin
               func_in = req_func;
               idx_in  = '0;
               bcd_in  = '0;
               cnt_in  = i2a_pkg::BCD_LAST_BIT;
               neg_in  = 1'b0;
               unique case (req_func)
                  i2a_pkg::FUNC_DEC: begin
                     neg_in  = low[i2a_pkg::LOW_W-1];
                     work_in = {{(i2a_pkg::VALUE_W-i2a_pkg::LOW_W){1'b0}},
                                low[i2a_pkg::LOW_W-1] ? (~low + 32'd1) : low};
                     ndig_in = i2a_pkg::NDIG_DEC;
                  end
                  i2a_pkg::FUNC_PTR: begin
                     work_in = req_value;
                     ndig_in = i2a_pkg::NDIG_PTR;
                  end
                  default: begin
                     work_in = {low, {(i2a_pkg::VALUE_W-i2a_pkg::LOW_W){1'b0}}};
                     ndig_in = i2a_pkg::NDIG_HEX;
                  end
               endcase
            end
            i2a_pkg::OP_BCD: begin
               // shift-and-add-3, one binary bit per step
               bcd_in  = {bcd_adj[i2a_pkg::BCD_W-2:0], work_ff[i2a_pkg::LOW_W-1]};
               work_in = {work_ff[i2a_pkg::VALUE_W-2:0], 1'b0};
               cnt_in  = cnt_ff - 5'd1;
            end
            i2a_pkg::OP_UNPACK: begin
               work_in = {bcd_ff, {(i2a_pkg::VALUE_W-i2a_pkg::BCD_W){1'b0}}};
               ndig_in = i2a_pkg::NDIG_DEC;
            end
            i2a_pkg::OP_SKIP: begin
               if (more) begin
                  work_in = {work_ff[i2a_pkg::VALUE_W-5:0], 4'd0};
                  ndig_in = ndig_ff - 5'd1;
               end
            end
            i2a_pkg::OP_EMIT: begin
               if (ctrl.emit) idx_in = idx_ff + 5'd1;
            end
            i2a_pkg::OP_DIGIT: begin
               work_in = {work_ff[i2a_pkg::VALUE_W-5:0], 4'd0};
               ndig_in = ndig_ff - 5'd1;
               idx_in  = idx_ff + 5'd1;
            end
            default: begin
               work_in = work_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (ctrl.chr)
         i2a_pkg::CH_MINUS: rsp_char_in = i2a_pkg::ASC_MINUS;
         i2a_pkg::CH_ZERO:  rsp_char_in = i2a_pkg::ASC_ZERO;
         i2a_pkg::CH_X:     rsp_char_in = i2a_pkg::ASC_X;
         default:           rsp_char_in = digit_char(top_nib,
                                                     func_ff == i2a_pkg::FUNC_UPPER);
      endcase
      rsp_index_in = idx_ff;
      rsp_last_in  = (ctrl.chr == i2a_pkg::CH_DIGIT) && (ndig_ff == 5'd1);
      // load a new beat, else drop the old one once it is taken
      rsp_valid_in = ctrl.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      bcd_ff  <= bcd_in;
      ndig_ff <= ndig_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      neg_ff  <= neg_in;
      func_ff <= func_in;
      if (ctrl.emit) begin
         rsp_char_ff  <= rsp_char_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_char_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> hdl/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter: top level joining sequencer and datapath.
//
// Formats one integer per request beat as decimal, lower or upper hex, or a
// "0x" pointer, and sends one character per response beat, most significant
// first, with its index and a last flag on the final character. One request
// is in work at a time; req_stall stays high from acceptance until the
// microprogram returns to its idle step. The program runs one step per
// cycle, but a step that sends a character holds while the previous one
// still waits on rsp_stall. The steps are one load step, then in decimal
// mode 32 shift-and-add-3 steps and one unpack step, then one step per
// leading zero digit plus one, three prefix steps (a sign or "0x" character
// is sent there if the format needs one), and one step per digit.
module integer_to_ascii_formatter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [i2a_pkg::VALUE_W-1:0] req_value,
   input  logic [i2a_pkg::FUNC_W-1:0]  req_func,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [i2a_pkg::CHAR_W-1:0]  rsp_ascii_char,
   output logic [i2a_pkg::INDEX_W-1:0] rsp_char_index,
   output logic                        rsp_last
);

   i2a_pkg::ctrl_type   ctrl;
   i2a_pkg::status_type status;

   assign req_stall = (ctrl.op != i2a_pkg::OP_IDLE);

   i2a_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .status    (status),
      .ctrl      (ctrl)
   );

   i2a_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_value      (req_value),
      .req_func       (req_func),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_char_index (rsp_char_index),
      .rsp_last       (rsp_last)
   );

endmodule

>>> dv/integer_to_ascii_formatter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the integer to ASCII formatter: driver, predictor and monitor.
module integer_to_ascii_formatter_top_tb;

   localparam int RANDOM_NUMBERS = 358;
   localparam int IDLE_PERCENT   = 26;
   localparam int CALM_FIRST     = 150;
   localparam int CALM_LAST      = 250;
   localparam int DRAIN_CYCLES   = 200;
   localparam int QUIET_LIMIT    = 4000;

   typedef struct {
      logic [i2a_pkg::VALUE_W-1:0] value;
      logic [i2a_pkg::FUNC_W-1:0]  func;
   } number_type;

   typedef struct packed {
      logic [i2a_pkg::CHAR_W-1:0]  ascii;
      logic [i2a_pkg::INDEX_W-1:0] index;
      logic                        last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [i2a_pkg::VALUE_W-1:0] req_value = '0;
   logic [i2a_pkg::FUNC_W-1:0]  req_func  = i2a_pkg::FUNC_DEC;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [i2a_pkg::CHAR_W-1:0]  rsp_ascii_char;
   logic [i2a_pkg::INDEX_W-1:0] rsp_char_index;
   logic                        rsp_last;

   number_type    pending_numbers [$];
   text_char_type expected_text [$];
   text_char_type want;
   number_type    item;
   int            n_taken = 0;
   int            n_errors = 0;
   int            quiet_cycles = 0;
   logic          calm;

   integer_to_ascii_formatter_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_func       (req_func),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_char_index (rsp_char_index),
      .rsp_last       (rsp_last)
   );

   always #1 clock = ~clock;

   // no idling on either side while this window of numbers goes through
   assign calm = (n_taken >= CALM_FIRST) && (n_taken < CALM_LAST);

   // Work out the text for one number and queue its characters.
   function automatic void format_number(logic [i2a_pkg::VALUE_W-1:0] value,
                                         logic [i2a_pkg::FUNC_W-1:0] func);
      logic [7:0]                  text [18];
      logic [7:0]                  rev [20];
      logic [i2a_pkg::VALUE_W-1:0] mag;
      logic [i2a_pkg::LOW_W-1:0]   low;
      int unsigned                 radix;
      int                          len;
      int                          n;
      int                          d;
      bit                          upper;
      text_char_type               beat;
      low   = value[i2a_pkg::LOW_W-1:0];
      len   = 0;
      n     = 0;
      radix = 16;
      upper = 1'b0;
      case (func)
         i2a_pkg::FUNC_DEC: begin
            radix = 10;
            mag   = {32'd0, low};
            if (low[i2a_pkg::LOW_W-1]) begin
               text[0] = "-";
               len     = 1;
               mag     = {32'd0, -low};
            end
         end
         i2a_pkg::FUNC_LOWER: mag = {32'd0, low};
         i2a_pkg::FUNC_UPPER: begin
            mag   = {32'd0, low};
            upper = 1'b1;
         end
         default: begin
            text[0] = "0";
            text[1] = "x";
            len     = 2;
            mag     = value;
         end
      endcase
      // digits come out least significant first
      do begin
         d = int'(mag % radix);
         if (d < 10)
            rev[n] = 8'("0" + d);
         else if (upper)
            rev[n] = 8'("A" + d - 10);
         else
            rev[n] = 8'("a" + d - 10);
         n++;
         mag = mag / radix;
      end while (mag != 0);
      while (n > 0) begin
         n--;
         text[len] = rev[n];
         len++;
      end
      for (int k = 0; k < len; k++) begin
         beat.ascii = text[k][i2a_pkg::CHAR_W-1:0];
         beat.index = i2a_pkg::INDEX_W'(k);
         beat.last  = (k == len - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // Driver: hold a stalled beat, otherwise offer the next number or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            format_number(req_value, req_func);
            n_taken <= n_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_numbers.size() != 0 &&
                (calm || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
               item = pending_numbers.pop_front();
               req_valid <= 1'b1;
               req_value <= item.value;
               req_func  <= item.func;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted character against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("unexpected character beat: ascii_char %h char_index %0d last %b",
                      rsp_ascii_char, rsp_char_index, rsp_last);
               n_errors++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_ascii_char !== want.ascii) begin
                  $error("ascii_char: expected %h, got %h", want.ascii, rsp_ascii_char);
                  n_errors++;
               end
               if (rsp_char_index !== want.index) begin
                  $error("char_index: expected %0d, got %0d", want.index, rsp_char_index);
                  n_errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  n_errors++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99, 0) < IDLE_PERCENT);
      end
   end

   // Watchdog: give up when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** integer_to_ascii_formatter_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // zeros, sign handling, widest texts and ignored upper bits
      pending_numbers.push_back('{64'h0, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'h1, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'hFFFF_FFFF, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'h7FFF_FFFF, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'h8000_0000, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'h3B9A_CA00, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'hDEAD_BEEF_0000_007B, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'hFFFF_FFFF_0000_0000, i2a_pkg::FUNC_DEC});
      pending_numbers.push_back('{64'h0, i2a_pkg::FUNC_LOWER});
      pending_numbers.push_back('{64'hFFFF_FFFF, i2a_pkg::FUNC_LOWER});
      pending_numbers.push_back('{64'h1234_5678_0000_ABCD, i2a_pkg::FUNC_LOWER});
      pending_numbers.push_back('{64'h89AB_CDEF, i2a_pkg::FUNC_LOWER});
      pending_numbers.push_back('{64'h0, i2a_pkg::FUNC_UPPER});
      pending_numbers.push_back('{64'hFFFF_FFFF, i2a_pkg::FUNC_UPPER});
      pending_numbers.push_back('{64'h89AB_CDEF, i2a_pkg::FUNC_UPPER});
      pending_numbers.push_back('{64'hFFFF_FFFF_0000_0000, i2a_pkg::FUNC_UPPER});
      pending_numbers.push_back('{64'h0, i2a_pkg::FUNC_PTR});
      pending_numbers.push_back('{64'h1, i2a_pkg::FUNC_PTR});
      pending_numbers.push_back('{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::FUNC_PTR});
      pending_numbers.push_back('{64'h8000_0000_0000_0000, i2a_pkg::FUNC_PTR});
      pending_numbers.push_back('{64'h0000_0000_FFFF_FFFF, i2a_pkg::FUNC_PTR});
      pending_numbers.push_back('{64'h1234_5678_9ABC_DEF0, i2a_pkg::FUNC_PTR});
      repeat (RANDOM_NUMBERS) begin
         item.func  = i2a_pkg::FUNC_W'($urandom_range(3, 0));
         case ($urandom_range(9, 0))
            0, 1: item.value = {$urandom, $urandom};
            // small negatives in decimal, small all-ones patterns in hex
            2: item.value = {$urandom, ~32'($urandom_range(20, 0))};
            default: item.value = {$urandom, $urandom} >> $urandom_range(63, 0);
         endcase
         pending_numbers.push_back(item);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_numbers.size() != 0 || req_valid || expected_text.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0)
         $display("** integer_to_ascii_formatter_top: PASSED **");
      else
         $display("** integer_to_ascii_formatter_top: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
hdl/i2a_pkg.sv
hdl/i2a_seq.sv
hdl/i2a_dp.sv
hdl/integer_to_ascii_formatter_top.sv
dv/integer_to_ascii_formatter_top_tb.sv
